[sv/psched_pkg.sv]
`default_nettype none

package psched_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   // One entry of the process table.
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] remaining;
      logic [31:0] arrival;
      logic [15:0] burst;
   } slot_type;

   typedef struct packed {
      logic capture;     // item accepted, latch its payload
      logic arrive;      // store an arrival
      logic scan_read;   // read the table entry at the scan counter
      logic pick;        // run the chosen process for one time unit
      logic turn;        // compute the turnaround time
      logic wait_calc;   // compute the waiting time
      logic load_rsp;    // move the finished result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_tick;
      logic scan_last;
      logic pick_finish;
      logic rsp_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

[sv/psched_if.sv]
`default_nettype none

interface psched_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [3:0]  proc_id;
   logic [7:0]  prio_level;
   logic [15:0] burst_len;

   modport source (output valid, command, proc_id, prio_level, burst_len, input ready);
   modport sink (input valid, command, proc_id, prio_level, burst_len, output ready);
endinterface

interface psched_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        idle;
   logic [3:0]  running_id;
   logic        finished;
   logic [31:0] finish_time;
   logic [31:0] turnaround;
   logic [31:0] waiting;

   modport source (output valid, accepted, idle, running_id, finished, finish_time,
                   turnaround, waiting, input ready);
   modport sink (input valid, accepted, idle, running_id, finished, finish_time,
                 turnaround, waiting, output ready);
endinterface

`default_nettype wire

[sv/preemptive_priority_scheduler_top.sv]
`default_nettype none

// Preemptive priority scheduler with one result per item. An arrival item
// (command 0) stores a process in the slot named by proc_id and answers with
// accepted set, or clear if the id is out of range, the slot is in use or the
// burst is zero; the next item is taken only once its result has been loaded. A
// tick item (command 1) advances the saturating time by one and runs the ready
// process with the smallest priority number (ties: earlier arrival, then lower
// id); the result reports the running id, or idle, and on completion the
// finish, turnaround and waiting times. A tick scans the process table memory, which
// is read one slot per cycle, and a completion adds the turnaround and waiting steps.
// A new item is taken while the previous result still waits in the output
// register.
module preemptive_priority_scheduler_top (
   input  wire logic   clock,
   input  wire logic   reset,
   psched_req_if.sink  req,
   psched_rsp_if.source rsp
);

   psched_pkg::ctrl_cmd_type  cmd;
   psched_pkg::ctrl_stat_type stat;

   psched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psched_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req.command),
      .req_proc_id     (req.proc_id),
      .req_prio_level  (req.prio_level),
      .req_burst_len   (req.burst_len),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_accepted    (rsp.accepted),
      .rsp_idle        (rsp.idle),
      .rsp_running_id  (rsp.running_id),
      .rsp_finished    (rsp.finished),
      .rsp_finish_time (rsp.finish_time),
      .rsp_turnaround  (rsp.turnaround),
      .rsp_waiting     (rsp.waiting)
   );

endmodule

`default_nettype wire

[sv/psched_ctrl.sv]
`default_nettype none

module psched_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire psched_pkg::ctrl_stat_type stat,
   output psched_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_ARRIVE = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_DRAIN  = 8'b0000_1000,
      S_PICK   = 8'b0001_0000,
      S_TURN   = 8'b0010_0000,
      S_WAIT   = 8'b0100_0000,
      S_RESULT = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = stat.req_is_tick ? S_SCAN : S_ARRIVE;
            end
         end
         S_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = S_RESULT;
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         // The last table read is compared during this cycle.
         S_DRAIN: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = stat.pick_finish ? S_TURN : S_RESULT;
         end
         S_TURN: begin
            cmd.turn = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.wait_calc = 1'b1;
            state_in      = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/psched_dpath.sv]
`default_nettype none

module psched_dpath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire psched_pkg::ctrl_cmd_type  cmd,
   output psched_pkg::ctrl_stat_type      stat,
   input  wire logic                      req_command,
   input  wire logic [3:0]                req_proc_id,
   input  wire logic [7:0]                req_prio_level,
   input  wire logic [15:0]               req_burst_len,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_accepted,
   output logic                           rsp_idle,
   output logic [3:0]                     rsp_running_id,
   output logic                           rsp_finished,
   output logic [31:0]                    rsp_finish_time,
   output logic [31:0]                    rsp_turnaround,
   output logic [31:0]                    rsp_waiting
);

   localparam int SW = psched_pkg::SLOT_W;

   // Captured item
   logic [3:0]  cap_id_ff;
   logic [7:0]  cap_prio_ff;
   logic [15:0] cap_burst_ff;

   // Process table: valid bits in flops, entries in a memory
   logic [psched_pkg::NUM_SLOTS-1:0] slot_valid_ff;
   psched_pkg::slot_type             slot_mem [psched_pkg::NUM_SLOTS];

   logic [SW-1:0]        scan_cnt_ff;
   logic                 rd_pend_ff;
   logic [SW-1:0]        rd_idx_ff;
   logic                 rd_valid_ff;
   psched_pkg::slot_type rd_word_ff;

   logic                 found_ff;
   logic [SW-1:0]        best_idx_ff;
   psched_pkg::slot_type best_word_ff;

   logic [31:0] now_ff;

   // Result being assembled
   logic        st_accepted_ff;
   logic        st_idle_ff;
   logic [3:0]  st_id_ff;
   logic        st_finished_ff;
   logic [31:0] st_time_ff;
   logic [31:0] st_ta_ff;
   logic [31:0] st_wt_ff;

   logic        rsp_valid_ff;
   logic        rsp_accepted_ff;
   logic        rsp_idle_ff;
   logic [3:0]  rsp_id_ff;
   logic        rsp_finished_ff;
   logic [31:0] rsp_time_ff;
   logic [31:0] rsp_ta_ff;
   logic [31:0] rsp_wt_ff;

   logic [SW-1:0]        arr_idx;
   logic                 arrive_ok;
   logic                 better;
   logic [15:0]          rem_dec;
   logic                 pick_finish;
   logic [31:0]          time_next;
   logic                 wr_en;
   logic [SW-1:0]        wr_addr;
   psched_pkg::slot_type wr_data;

   assign arr_idx   = SW'(cap_id_ff);
   assign arrive_ok = (32'(cap_id_ff) < 32'(psched_pkg::NUM_SLOTS))
                      && !slot_valid_ff[arr_idx] && (cap_burst_ff != 16'd0);

   // Strictly better only, so on a full tie the lower slot seen first stays.
   assign better = !found_ff
                   || (rd_word_ff.prio < best_word_ff.prio)
                   || ((rd_word_ff.prio == best_word_ff.prio)
                       && (rd_word_ff.arrival < best_word_ff.arrival));

   assign rem_dec     = (best_word_ff.remaining == 16'd0) ? 16'd0
                                                          : best_word_ff.remaining - 16'd1;
   assign pick_finish = found_ff && (rem_dec == 16'd0);
   assign time_next   = (now_ff == psched_pkg::TIME_MAX) ? now_ff : now_ff + 32'd1;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_word_ff;
      if (cmd.arrive) begin
         wr_en             = arrive_ok;
         wr_addr           = arr_idx;
         wr_data.prio      = cap_prio_ff;
         wr_data.remaining = cap_burst_ff;
         wr_data.arrival   = now_ff;
         wr_data.burst     = cap_burst_ff;
      end else if (cmd.pick) begin
         wr_en             = found_ff;
         wr_data.remaining = rem_dec;
      end
   end

   assign stat.req_is_tick = req_command;
   assign stat.scan_last   = (scan_cnt_ff == SW'(psched_pkg::NUM_SLOTS - 1));
   assign stat.pick_finish = pick_finish;
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_read) begin
         rd_word_ff <= slot_mem[scan_cnt_ff];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         now_ff        <= '0;
         found_ff      <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_read;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (rd_pend_ff && rd_valid_ff && better) begin
            found_ff <= 1'b1;
         end
         if (cmd.arrive && arrive_ok) begin
            slot_valid_ff[arr_idx] <= 1'b1;
         end
         if (cmd.pick) begin
            now_ff <= time_next;
            if (pick_finish) begin
               slot_valid_ff[best_idx_ff] <= 1'b0;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_id_ff    <= req_proc_id;
         cap_prio_ff  <= req_prio_level;
         cap_burst_ff <= req_burst_len;
         scan_cnt_ff  <= '0;
      end else if (cmd.scan_read) begin
         scan_cnt_ff <= scan_cnt_ff + SW'(1);
      end
      if (cmd.scan_read) begin
         rd_idx_ff   <= scan_cnt_ff;
         rd_valid_ff <= slot_valid_ff[scan_cnt_ff];
      end
      if (rd_pend_ff && rd_valid_ff && better) begin
         best_idx_ff  <= rd_idx_ff;
         best_word_ff <= rd_word_ff;
      end
      if (cmd.arrive) begin
         st_accepted_ff <= arrive_ok;
         st_idle_ff     <= 1'b0;
         st_id_ff       <= 4'd0;
         st_finished_ff <= 1'b0;
         st_time_ff     <= 32'd0;
         st_ta_ff       <= 32'd0;
         st_wt_ff       <= 32'd0;
      end
      if (cmd.pick) begin
         st_accepted_ff <= 1'b0;
         st_idle_ff     <= !found_ff;
         st_id_ff       <= found_ff ? 4'(best_idx_ff) : 4'd0;
         st_finished_ff <= pick_finish;
         st_time_ff     <= time_next;
         st_ta_ff       <= 32'd0;
         st_wt_ff       <= 32'd0;
      end
      // The time has already advanced when the turnaround is formed.
      if (cmd.turn) begin
         st_ta_ff <= now_ff - best_word_ff.arrival;
      end
      if (cmd.wait_calc) begin
         st_wt_ff <= (st_ta_ff >= 32'(best_word_ff.burst))
                     ? st_ta_ff - 32'(best_word_ff.burst) : 32'd0;
      end
      if (cmd.load_rsp) begin
         rsp_accepted_ff <= st_accepted_ff;
         rsp_idle_ff     <= st_idle_ff;
         rsp_id_ff       <= st_id_ff;
         rsp_finished_ff <= st_finished_ff;
         rsp_time_ff     <= st_time_ff;
         rsp_ta_ff       <= st_ta_ff;
         rsp_wt_ff       <= st_wt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_idle        = rsp_idle_ff;
   assign rsp_running_id  = rsp_id_ff;
   assign rsp_finished    = rsp_finished_ff;
   assign rsp_finish_time = rsp_time_ff;
   assign rsp_turnaround  = rsp_ta_ff;
   assign rsp_waiting     = rsp_wt_ff;

   a_time_monotonic: assert property (@(posedge clock)
      !reset |=> (reset || (now_ff >= $past(now_ff))))
      else $error("time went backwards");

   a_time_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !cmd.pick |=> $stable(now_ff))
      else $error("time changed outside a tick");

   a_best_is_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.pick && found_ff) |-> slot_valid_ff[best_idx_ff])
      else $error("chosen slot is not in use");

   a_finish_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.pick && pick_finish) |=> !slot_valid_ff[$past(best_idx_ff)])
      else $error("finished process still holds its slot");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/tb_preemptive_priority_scheduler_top.sv]
`timescale 1ns / 100ps

typedef enum bit {
   CMD_ARRIVE = 1'b0,
   CMD_TICK   = 1'b1
} sched_cmd_type;

typedef struct packed {
   logic        accepted;
   logic        idle;
   logic [3:0]  running_id;
   logic        finished;
   logic [31:0] finish_time;
   logic [31:0] turnaround;
   logic [31:0] waiting;
} sched_outcome_type;

// Keeps its own copy of the process table and the clock, works out the
// outcome of every accepted item and checks the block's results in order.
class sched_checker;
   bit                busy[psched_pkg::NUM_SLOTS];
   bit [7:0]          prio[psched_pkg::NUM_SLOTS];
   bit [15:0]         left[psched_pkg::NUM_SLOTS];
   bit [31:0]         arrived[psched_pkg::NUM_SLOTS];
   bit [15:0]         length[psched_pkg::NUM_SLOTS];
   bit [31:0]         now_t;
   sched_outcome_type pending_outcomes[$];
   int                mismatches;

   function bit goes_first(int a, int b);
      if (prio[a] != prio[b]) return prio[a] < prio[b];
      if (arrived[a] != arrived[b]) return arrived[a] < arrived[b];
      return a < b;
   endfunction

   function int busy_count();
      int n;
      n = 0;
      for (int s = 0; s < psched_pkg::NUM_SLOTS; s++) n += busy[s];
      return n;
   endfunction

   function int outstanding();
      return pending_outcomes.size();
   endfunction

   function void note_item(sched_cmd_type cmd, bit [3:0] id, bit [7:0] p, bit [15:0] len);
      sched_outcome_type o;
      int                pick;
      bit                found;
      bit [31:0]         ta;
      o = '0;
      pick = 0;
      found = 0;
      if (cmd == CMD_ARRIVE) begin
         if (id < psched_pkg::NUM_SLOTS && !busy[id] && len != 0) begin
            busy[id] = 1;
            prio[id] = p;
            left[id] = len;
            length[id] = len;
            arrived[id] = now_t;
            o.accepted = 1;
         end
      end else begin
         for (int s = 0; s < psched_pkg::NUM_SLOTS; s++) begin
            if (busy[s] && (!found || goes_first(s, pick))) begin
               pick = s;
               found = 1;
            end
         end
         if (now_t != psched_pkg::TIME_MAX) now_t++;
         o.finish_time = now_t;
         if (!found) begin
            o.idle = 1;
         end else begin
            o.running_id = pick[3:0];
            if (left[pick] > 0) left[pick]--;
            if (left[pick] == 0) begin
               ta = now_t - arrived[pick];
               busy[pick] = 0;
               o.finished = 1;
               o.turnaround = ta;
               o.waiting = (ta >= length[pick]) ? ta - length[pick] : 32'd0;
            end
         end
      end
      pending_outcomes.insert(pending_outcomes.size(), o);
   endfunction

   function void check_result(sched_outcome_type got);
      sched_outcome_type want;
      if (pending_outcomes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with nothing expected: %p", $time, got);
         return;
      end
      want = pending_outcomes.pop_front();
      if (got.accepted !== want.accepted || got.idle !== want.idle ||
          got.running_id !== want.running_id || got.finished !== want.finished ||
          got.finish_time !== want.finish_time || got.turnaround !== want.turnaround ||
          got.waiting !== want.waiting) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: mismatch", $time);
            $display("   expected acc=%b idle=%b id=%0d fin=%b time=%0d ta=%0d wt=%0d",
                     want.accepted, want.idle, want.running_id, want.finished,
                     want.finish_time, want.turnaround, want.waiting);
            $display("   actual   acc=%b idle=%b id=%0d fin=%b time=%0d ta=%0d wt=%0d",
                     got.accepted, got.idle, got.running_id, got.finished,
                     got.finish_time, got.turnaround, got.waiting);
         end
      end
   endfunction
endclass

module tb_preemptive_priority_scheduler_top;

   localparam int RANDOM_ITEMS = 580;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;

   logic clock;
   logic reset;
   int   items_sent;
   int   burst_left;

   sched_checker sched_model = new();

   psched_req_if req_if();
   psched_rsp_if rsp_if();

   preemptive_priority_scheduler_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one item, possibly inserting an idle gap first when the current burst is used up.
   task automatic offer(sched_cmd_type cmd, bit [3:0] id, bit [7:0] p, bit [15:0] len);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.proc_id    <= id;
      req_if.prio_level <= p;
      req_if.burst_len  <= len;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sched_model.note_item(cmd, id, p, len);
      items_sent++;
   endtask

   // Ticks dominate when the table is crowded and arrivals when it is nearly empty,
   // so the table keeps filling and draining.
   task automatic offer_random();
      int         occupied;
      int         tick_pct;
      bit [7:0]   p;
      bit [15:0]  len;
      occupied = sched_model.busy_count();
      tick_pct = (occupied >= 12) ? 85 : (occupied <= 3) ? 30 : 60;
      if ($urandom_range(0, 99) < tick_pct) begin
         offer(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom), 16'($urandom));
      end else begin
         p = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                        : 8'($urandom_range(0, 255));
         case ($urandom_range(0, 19))
            0:       len = 16'd0;
            1, 2, 3: len = 16'($urandom_range(4, 24));
            default: len = 16'($urandom_range(1, 3));
         endcase
         offer(CMD_ARRIVE, 4'($urandom_range(0, 15)), p, len);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_ARRIVE;
      req_if.proc_id = '0;
      req_if.prio_level = '0;
      req_if.burst_len = '0;
      items_sent = 0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      offer(CMD_TICK, 4'd0, 8'd0, 16'd0);             // empty table: idle tick
      offer(CMD_ARRIVE, 4'd0, 8'd5, 16'd0);           // zero burst is refused
      offer(CMD_ARRIVE, 4'd15, 8'd255, 16'hFFFF);     // long, least urgent process
      offer(CMD_ARRIVE, 4'd15, 8'd0, 16'd1);          // slot in use is refused
      offer(CMD_TICK, 4'd0, 8'd0, 16'd0);
      offer(CMD_ARRIVE, 4'd7, 8'd10, 16'd2);
      offer(CMD_ARRIVE, 4'd3, 8'd10, 16'd1);          // same priority and time: lower id wins
      offer(CMD_TICK, 4'd0, 8'd0, 16'd0);
      offer(CMD_ARRIVE, 4'd2, 8'd10, 16'd1);          // same priority, later arrival loses
      offer(CMD_TICK, 4'd0, 8'd0, 16'd0);
      offer(CMD_ARRIVE, 4'd9, 8'd0, 16'd2);           // most urgent arrival preempts
      repeat (5) offer(CMD_TICK, 4'd0, 8'd0, 16'd0);
      offer(CMD_ARRIVE, 4'd0, 8'd128, 16'd3);
      repeat (4) offer(CMD_TICK, 4'd0, 8'd0, 16'd0);

      repeat (RANDOM_ITEMS) offer_random();

      req_if.valid <= 1'b0;
      while (sched_model.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sched_model.mismatches == 0 && sched_model.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Result side: checks every accepted result and drives ready from a changing
   // pattern, with one long hold-off that backs the block up into its input.
   initial begin
      sched_outcome_type got;
      int                mode;
      int                window;
      int                hold_left;
      bit                hold_done;
      mode = 0;
      window = 0;
      hold_left = 0;
      hold_done = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.accepted    = rsp_if.accepted;
            got.idle        = rsp_if.idle;
            got.running_id  = rsp_if.running_id;
            got.finished    = rsp_if.finished;
            got.finish_time = rsp_if.finish_time;
            got.turnaround  = rsp_if.turnaround;
            got.waiting     = rsp_if.waiting;
            sched_model.check_result(got);
         end
         if (!hold_done && items_sent >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (window == 0) begin
            mode = $urandom_range(0, 2);
            window = $urandom_range(16, 96);
         end else begin
            window--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

endmodule
